/* hdl/mct_pkg.sv */
// ----------------------------------------------------------------------------
// mct_pkg
// element formats, matrix and vector types, constants shared by the
// column transform unit
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIM       = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // column-major: entry col*4+row
  typedef elem_t [DIM*DIM-1:0] mat_t;
  typedef elem_t [DIM-1:0]     vec_t;
  // products indexed [row][col]
  typedef prod_t [DIM-1:0][DIM-1:0] prod_mat_t;
  typedef pair_t [DIM-1:0][1:0]     pair_mat_t;

  typedef enum logic {
    ACT_LOAD      = 1'b0,
    ACT_TRANSFORM = 1'b1
  } action_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  // 1.0 in fixed point, clipped to the largest element if it does not fit
  localparam elem_t ELEM_ONE = (FRAC_BITS < ELEM_W - 1) ?
                               elem_t'(64'd1 << FRAC_BITS) : ELEM_MAX;

  typedef struct packed {
    elem_t [DIM-1:0] elem;
    logic            saturated;
  } result_t;

endpackage

/* hdl/mct_req_if.sv */
// ----------------------------------------------------------------------------
// mct_req_if
// request channel: one load or transform item with valid/ready
// ----------------------------------------------------------------------------
interface mct_req_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [1:0]           column_index;
  mct_pkg::elem_t       in_x;
  mct_pkg::elem_t       in_y;
  mct_pkg::elem_t       in_z;
  mct_pkg::elem_t       in_w;

  modport source (output valid, action, column_index, in_x, in_y, in_z, in_w,
                  input ready);
  modport sink   (input valid, action, column_index, in_x, in_y, in_z, in_w,
                  output ready);
endinterface

/* hdl/mct_rsp_if.sv */
// ----------------------------------------------------------------------------
// mct_rsp_if
// result channel: transformed vector and saturation flag with valid/ready
// ----------------------------------------------------------------------------
interface mct_rsp_if;
  logic           valid;
  logic           ready;
  mct_pkg::elem_t out_x;
  mct_pkg::elem_t out_y;
  mct_pkg::elem_t out_z;
  mct_pkg::elem_t out_w;
  logic           saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated,
                  output ready);
endinterface

/* hdl/mct_matrix.sv */
// ----------------------------------------------------------------------------
// mct_matrix
// left matrix register file, one column written per load, identity on reset
// ----------------------------------------------------------------------------
module mct_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [1:0]         col,
  input  mct_pkg::vec_t      vec,
  output mct_pkg::mat_t      mat
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < mct_pkg::DIM; c++) begin
        for (int r = 0; r < mct_pkg::DIM; r++) begin
          mat[c*mct_pkg::DIM + r] <= (c == r) ? mct_pkg::ELEM_ONE : '0;
        end
      end
    end else if (we) begin
      for (int r = 0; r < mct_pkg::DIM; r++) begin
        mat[{col, 2'(r)}] <= vec[r];
      end
    end
  end

endmodule

/* hdl/mct_mul.sv */
// ----------------------------------------------------------------------------
// mct_mul
// first stage: sixteen full-width signed products, registered
// ----------------------------------------------------------------------------
module mct_mul (
  input  logic                 clk,
  input  logic                 en,
  input  mct_pkg::mat_t        mat,
  input  mct_pkg::vec_t        vec,
  output mct_pkg::prod_mat_t   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < mct_pkg::DIM; r++) begin
        for (int c = 0; c < mct_pkg::DIM; c++) begin
          prod[r][c] <= mct_pkg::prod_t'(mat[c*mct_pkg::DIM + r])
                      * mct_pkg::prod_t'(vec[c]);
        end
      end
    end
  end

endmodule

/* hdl/mct_sum.sv */
// ----------------------------------------------------------------------------
// mct_sum
// second stage: pairwise sums; third stage: final sum, shift and saturate
// ----------------------------------------------------------------------------
module mct_sum (
  input  logic                 clk,
  input  logic                 en_pair,
  input  logic                 en_out,
  input  mct_pkg::prod_mat_t   prod,
  output mct_pkg::result_t     result
);

  mct_pkg::pair_mat_t pair;
  mct_pkg::result_t   result_next;

  always_ff @(posedge clk) begin
    if (en_pair) begin
      for (int r = 0; r < mct_pkg::DIM; r++) begin
        pair[r][0] <= mct_pkg::pair_t'(prod[r][0]) + mct_pkg::pair_t'(prod[r][1]);
        pair[r][1] <= mct_pkg::pair_t'(prod[r][2]) + mct_pkg::pair_t'(prod[r][3]);
      end
    end
  end

  always_comb begin
    mct_pkg::sum_t total;
    mct_pkg::sum_t shifted;
    logic          all_ones;
    logic          all_zero;
    result_next.saturated = 1'b0;
    for (int r = 0; r < mct_pkg::DIM; r++) begin
      total    = mct_pkg::sum_t'(pair[r][0]) + mct_pkg::sum_t'(pair[r][1]);
      shifted  = total >>> mct_pkg::FRAC_BITS;
      // in range when every bit above the element's sign bit matches it
      all_ones = &shifted[mct_pkg::SUM_W-1:mct_pkg::ELEM_W-1];
      all_zero = ~|shifted[mct_pkg::SUM_W-1:mct_pkg::ELEM_W-1];
      if (all_ones || all_zero) begin
        result_next.elem[r] = shifted[mct_pkg::ELEM_W-1:0];
      end else begin
        result_next.elem[r]   = shifted[mct_pkg::SUM_W-1] ? mct_pkg::ELEM_MIN
                                                         : mct_pkg::ELEM_MAX;
        result_next.saturated = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result <= result_next;
    end
  end

endmodule

/* hdl/matrix4_column_transform_unit.sv */
// ----------------------------------------------------------------------------
// matrix4_column_transform_unit
// a transform request passes the product, pair-sum and output registers
// throughput: one request per cycle while result.ready does not hold the pipeline, loads and transforms alike
// a load takes effect for the very next transform request
// rst is synchronous: left matrix returns to identity, pipeline empties
// ----------------------------------------------------------------------------
module matrix4_column_transform_unit (
  input  logic         clk,
  input  logic         rst,
  mct_req_if.sink      request,
  mct_rsp_if.source    result
);

  // pipeline valid bits, one per register stage
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;

  // a stage may take new data when it is empty or its contents move on
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  logic req_fire;
  logic load_fire;
  logic xform_fire;

  mct_pkg::vec_t      vec;
  mct_pkg::mat_t      mat;
  mct_pkg::prod_mat_t prod;
  mct_pkg::result_t   res;

  assign s3_ready = !s3_valid || result.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign request.ready = s1_ready;

  assign req_fire   = request.valid && s1_ready;
  assign load_fire  = req_fire && (request.action == mct_pkg::ACT_LOAD);
  assign xform_fire = req_fire && (request.action == mct_pkg::ACT_TRANSFORM);

  assign vec[0] = request.in_x;
  assign vec[1] = request.in_y;
  assign vec[2] = request.in_z;
  assign vec[3] = request.in_w;

  // matrix write and product capture happen on the same edge, so a
  // transform always sees every load accepted before it
  mct_matrix u_matrix (
    .clk (clk),
    .rst (rst),
    .we  (load_fire),
    .col (request.column_index),
    .vec (vec),
    .mat (mat)
  );

  // stage 1: products
  mct_mul u_mul (
    .clk  (clk),
    .en   (s1_ready),
    .mat  (mat),
    .vec  (vec),
    .prod (prod)
  );

  // stages 2 and 3: adder tree, shift, saturation into the output register
  mct_sum u_sum (
    .clk     (clk),
    .en_pair (s2_ready),
    .en_out  (s3_ready),
    .prod    (prod),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      // loads leave no result, so only transforms enter the pipeline
      if (s1_ready) begin
        s1_valid <= xform_fire;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  assign result.valid     = s3_valid;
  assign result.out_x     = res.elem[0];
  assign result.out_y     = res.elem[1];
  assign result.out_z     = res.elem[2];
  assign result.out_w     = res.elem[3];
  assign result.saturated = res.saturated;

endmodule
